// ===== sv/vnet_mmio_pkg.sv =====
// ----------------------------------------------------------------------------
// vnet_mmio_pkg
// Shared constants, register map and stage types of the legacy virtio-mmio
// network device register block.
// ----------------------------------------------------------------------------
package vnet_mmio_pkg;

    // default sizing
    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int DEF_QUEUE_COUNT = 2;

    // fixed register contents
    localparam logic [31:0] MAGIC_WORD  = 32'h7472_6976;
    localparam logic [31:0] VENDOR_WORD = 32'h554D_4551;
    localparam logic [31:0] VERSION     = 32'd1;
    localparam logic [31:0] TX_QUEUE    = 32'd1;

    // used ring sits 16*depth + 6 + 2*depth past the descriptor base, rounded up to a page
    localparam int DESC_BYTES  = 16;
    localparam int USED_HDR    = 6;
    localparam int AVAIL_ENTRY = 2;

    // opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register offsets
    localparam logic [8:0] REG_MAGIC     = 9'h000;
    localparam logic [8:0] REG_VERSION   = 9'h004;
    localparam logic [8:0] REG_DEVICE_ID = 9'h008;
    localparam logic [8:0] REG_VENDOR    = 9'h00C;
    localparam logic [8:0] REG_FEATURES  = 9'h010;
    localparam logic [8:0] REG_FEAT_SEL  = 9'h014;
    localparam logic [8:0] REG_PAGE_SIZE = 9'h028;
    localparam logic [8:0] REG_QUEUE_SEL = 9'h030;
    localparam logic [8:0] REG_QNUM_MAX  = 9'h034;
    localparam logic [8:0] REG_QUEUE_PFN = 9'h040;
    localparam logic [8:0] REG_NOTIFY    = 9'h050;
    localparam logic [8:0] REG_IRQ_STAT  = 9'h060;
    localparam logic [8:0] REG_IRQ_ACK   = 9'h064;
    localparam logic [8:0] REG_STATUS    = 9'h070;
    localparam logic [8:0] REG_MAC0      = 9'h100;
    localparam logic [8:0] REG_MAC1      = 9'h101;
    localparam logic [8:0] REG_MAC2      = 9'h102;
    localparam logic [8:0] REG_MAC3      = 9'h103;
    localparam logic [8:0] REG_MAC4      = 9'h104;
    localparam logic [8:0] REG_MAC5      = 9'h105;
    localparam logic [8:0] REG_LINK      = 9'h106;

    // configuration register indexes
    localparam logic [1:0] CFG_LINK_UP  = 2'd0;
    localparam logic [1:0] CFG_MAC      = 2'd1;
    localparam logic [1:0] CFG_FEATURES = 2'd2;

    localparam logic [47:0] MAC_RESET      = 48'h5254_0012_3456;
    localparam logic [31:0] FEATURES_RESET = 32'h0001_0020;

    // after decode and multiply
    typedef struct packed {
        logic [31:0] read_data;
        logic        kick;
        logic        irq_pulse;
        logic [63:0] dtab_addr;
        logic [31:0] page_mask;   // page size - 1
        logic [32:0] used_ofs;    // page size + used ring offset - 1
    } t_calc;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_kick;
        logic [63:0] tx_desc_base;
        logic [63:0] tx_avail_base;
        logic [63:0] tx_used_base;
        logic        irq_pulse;
    } t_result;

endpackage

// ===== sv/vnet_mmio_regs.sv =====
// ----------------------------------------------------------------------------
// vnet_mmio_regs
// Device state, bus decode, read mux and transmit base multiply.
// ----------------------------------------------------------------------------
module vnet_mmio_regs import vnet_mmio_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int QUEUE_COUNT = DEF_QUEUE_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [1:0]  i_opcode,
    input  logic [8:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic        i_link_up,
    input  logic [47:0] i_mac_address,
    input  logic [31:0] i_offered_features,
    output t_calc       o_calc
);

    localparam int QIDX_W = $clog2(QUEUE_COUNT);
    localparam logic [32:0] USED_OFS_M1 =
        33'(DESC_BYTES * QUEUE_DEPTH + USED_HDR + AVAIL_ENTRY * QUEUE_DEPTH - 1);

    logic [31:0] r_feat_sel, n_feat_sel;
    logic [31:0] r_queue_sel, n_queue_sel;
    logic [31:0] r_page_size, n_page_size;
    logic [31:0] r_queue_pfn [QUEUE_COUNT];
    logic [31:0] n_queue_pfn [QUEUE_COUNT];
    logic [31:0] r_irq_status, n_irq_status;
    logic [31:0] r_dev_status, n_dev_status;

    logic              sel_ok;
    logic [QIDX_W-1:0] sel_idx;
    logic [31:0]       tx_pfn;
    logic              kick;
    logic [31:0]       rd;

    assign sel_ok  = r_queue_sel < 32'(QUEUE_COUNT);
    assign sel_idx = r_queue_sel[QIDX_W-1:0];
    assign tx_pfn  = r_queue_pfn[QIDX_W'(TX_QUEUE)];

    assign kick = (i_opcode == OP_WRITE) && (i_reg_offset == REG_NOTIFY)
                  && (i_write_data == TX_QUEUE) && i_link_up
                  && (r_page_size != '0) && (tx_pfn != '0);

    // read mux
    always_comb begin
        rd = '0;
        unique case (i_reg_offset)
            REG_MAGIC:     rd = MAGIC_WORD;
            REG_VERSION:   rd = VERSION;
            REG_DEVICE_ID: rd = {31'b0, i_link_up};
            REG_VENDOR:    rd = VENDOR_WORD;
            REG_FEATURES:  rd = (r_feat_sel == '0) ? i_offered_features : '0;
            REG_QNUM_MAX:  rd = 32'(QUEUE_DEPTH);
            REG_QUEUE_PFN: rd = sel_ok ? r_queue_pfn[sel_idx] : '0;
            REG_IRQ_STAT:  rd = r_irq_status;
            REG_STATUS:    rd = r_dev_status;
            REG_MAC0:      rd = {24'b0, i_mac_address[47:40]};
            REG_MAC1:      rd = {24'b0, i_mac_address[39:32]};
            REG_MAC2:      rd = {24'b0, i_mac_address[31:24]};
            REG_MAC3:      rd = {24'b0, i_mac_address[23:16]};
            REG_MAC4:      rd = {24'b0, i_mac_address[15:8]};
            REG_MAC5:      rd = {24'b0, i_mac_address[7:0]};
            REG_LINK:      rd = {31'b0, i_link_up};
            default:       rd = '0;
        endcase
    end

    // next state
    always_comb begin
        n_feat_sel   = r_feat_sel;
        n_queue_sel  = r_queue_sel;
        n_page_size  = r_page_size;
        n_queue_pfn  = r_queue_pfn;
        n_irq_status = r_irq_status;
        n_dev_status = r_dev_status;
        if (i_opcode == OP_WRITE) begin
            unique case (i_reg_offset)
                REG_FEAT_SEL:  n_feat_sel  = i_write_data;
                REG_PAGE_SIZE: n_page_size = i_write_data;
                REG_QUEUE_SEL: n_queue_sel = i_write_data;
                REG_QUEUE_PFN: begin
                    if (sel_ok) begin
                        n_queue_pfn[sel_idx] = i_write_data;
                    end
                end
                REG_NOTIFY: begin
                    if (kick) begin
                        n_irq_status[0] = 1'b1;
                    end
                end
                REG_IRQ_ACK:   n_irq_status = r_irq_status & ~i_write_data;
                REG_STATUS: begin
                    n_dev_status = i_write_data;
                    if (i_write_data == '0) begin
                        for (int q = 0; q < QUEUE_COUNT; q++) begin
                            n_queue_pfn[q] = '0;
                        end
                        n_irq_status = '0;
                    end
                end
                default: ;
            endcase
        end else if (i_opcode == OP_RX) begin
            n_irq_status[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat_sel   <= '0;
            r_queue_sel  <= '0;
            r_page_size  <= '0;
            r_irq_status <= '0;
            r_dev_status <= '0;
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_queue_pfn[q] <= '0;
            end
        end else if (i_fire) begin
            r_feat_sel   <= n_feat_sel;
            r_queue_sel  <= n_queue_sel;
            r_page_size  <= n_page_size;
            r_irq_status <= n_irq_status;
            r_dev_status <= n_dev_status;
            r_queue_pfn  <= n_queue_pfn;
        end
    end

    always_comb begin
        o_calc.read_data = (i_opcode == OP_READ) ? rd : '0;
        o_calc.kick      = kick;
        o_calc.irq_pulse = kick || (i_opcode == OP_RX);
        o_calc.dtab_addr = kick ? (64'(tx_pfn) * 64'(r_page_size)) : '0;
        o_calc.page_mask = kick ? (r_page_size - 32'd1) : '0;
        o_calc.used_ofs  = kick ? (33'(r_page_size) + USED_OFS_M1) : '0;
    end

endmodule

// ===== sv/vnet_mmio_ring.sv =====
// ----------------------------------------------------------------------------
// vnet_mmio_ring
// Transmit ring base addresses: available ring and page-aligned used ring.
// ----------------------------------------------------------------------------
module vnet_mmio_ring import vnet_mmio_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  t_calc   i_calc,
    output t_result o_result
);

    localparam logic [63:0] AVAIL_OFS = 64'(DESC_BYTES * QUEUE_DEPTH);

    logic [63:0] used_raw;

    // desc + ring offset + page size - 1, then drop the page bits
    assign used_raw = i_calc.dtab_addr + 64'(i_calc.used_ofs);

    always_comb begin
        o_result.read_data     = i_calc.read_data;
        o_result.tx_kick       = i_calc.kick;
        o_result.irq_pulse     = i_calc.irq_pulse;
        o_result.tx_desc_base  = i_calc.dtab_addr;
        o_result.tx_avail_base = i_calc.kick ? (i_calc.dtab_addr + AVAIL_OFS) : '0;
        o_result.tx_used_base  = i_calc.kick ? (used_raw & ~{32'b0, i_calc.page_mask}) : '0;
    end

endmodule

// ===== sv/virtio_net_mmio_register_block.sv =====
// Path: an accepted beat passes the input register, the multiply stage and
// the output register in order. Throughput: one beat per cycle unless the
// output stalls; each holds one beat and advances when the next one is free.
// Reset: synchronous, active low; clears all device state, pipeline valids and
// loads the configuration defaults (link down, default MAC and features).
// ----------------------------------------------------------------------------
// virtio_net_mmio_register_block
// Legacy virtio-mmio network device register file with transmit kick output.
// ----------------------------------------------------------------------------
module virtio_net_mmio_register_block import vnet_mmio_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int QUEUE_COUNT = DEF_QUEUE_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [8:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_tx_kick,
    output logic [63:0] o_tx_desc_base,
    output logic [63:0] o_tx_avail_base,
    output logic [63:0] o_tx_used_base,
    output logic        o_irq_pulse
);

    logic        r_link_up;
    logic [47:0] r_mac;
    logic [31:0] r_features;

    logic        r_s0_valid;
    logic [1:0]  r_s0_opcode;
    logic [8:0]  r_s0_offset;
    logic [31:0] r_s0_data;

    logic        r_s1_valid;
    t_calc       r_s1;
    logic        r_out_valid;
    t_result     r_out;

    t_calc   s0_calc;
    t_result s1_result;
    logic    s0_adv, s1_adv, in_fire, s0_fire;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign s0_adv     = !r_s1_valid || s1_adv;
    assign o_in_ready = !r_s0_valid || s0_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign s0_fire    = r_s0_valid && s0_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up  <= 1'b0;
            r_mac      <= MAC_RESET;
            r_features <= FEATURES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINK_UP:  r_link_up  <= i_cfg_data[0];
                CFG_MAC:      r_mac      <= i_cfg_data;
                CFG_FEATURES: r_features <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s0_valid <= 1'b1;
            end else if (s0_adv) begin
                r_s0_valid <= 1'b0;
            end
            if (s0_adv) begin
                r_s1_valid <= r_s0_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s0_opcode <= i_opcode;
            r_s0_offset <= i_reg_offset;
            r_s0_data   <= i_write_data;
        end
        if (s0_adv) begin
            r_s1 <= s0_calc;
        end
        if (s1_adv) begin
            r_out <= s1_result;
        end
    end

    vnet_mmio_regs #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (s0_fire),
        .i_opcode           (r_s0_opcode),
        .i_reg_offset       (r_s0_offset),
        .i_write_data       (r_s0_data),
        .i_link_up          (r_link_up),
        .i_mac_address      (r_mac),
        .i_offered_features (r_features),
        .o_calc             (s0_calc)
    );

    vnet_mmio_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_calc   (r_s1),
        .o_result (s1_result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out.read_data;
    assign o_tx_kick       = r_out.tx_kick;
    assign o_tx_desc_base  = r_out.tx_desc_base;
    assign o_tx_avail_base = r_out.tx_avail_base;
    assign o_tx_used_base  = r_out.tx_used_base;
    assign o_irq_pulse     = r_out.irq_pulse;

endmodule

// ===== sv/vnet_mmio_checker.sv =====
// ----------------------------------------------------------------------------
// vnet_mmio_checker
// Port-level checks on the register block output beats.
// ----------------------------------------------------------------------------
module vnet_mmio_checker import vnet_mmio_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_tx_kick,
    input logic [63:0] o_tx_desc_base,
    input logic [63:0] o_tx_avail_base,
    input logic [63:0] o_tx_used_base,
    input logic        o_irq_pulse
);

    localparam logic [63:0] AVAIL_OFS = 64'(DESC_BYTES * QUEUE_DEPTH);

    // no beat comes out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_kick_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_kick |-> o_irq_pulse)
        else $error("kick without interrupt");

    a_no_kick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_kick |->
            o_tx_desc_base == '0 && o_tx_avail_base == '0 && o_tx_used_base == '0)
        else $error("ring bases nonzero without kick");

    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_kick |-> o_tx_avail_base == o_tx_desc_base + AVAIL_OFS)
        else $error("available ring base mismatch");

endmodule

bind virtio_net_mmio_register_block vnet_mmio_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_tx_kick       (o_tx_kick),
    .o_tx_desc_base  (o_tx_desc_base),
    .o_tx_avail_base (o_tx_avail_base),
    .o_tx_used_base  (o_tx_used_base),
    .o_irq_pulse     (o_irq_pulse)
);
